[rtl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 stream hasher: beat layouts,
// word vectors, the initial hash value and the round constant table.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] word_t;

    // Eight round variables or hash words, index 0 holds a / H0
    typedef logic [7:0][31:0] work_t;

    // Sixteen-word block window, index 15 holds the oldest word
    typedef logic [15:0][31:0] sched_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } out_beat_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // Index 7 is written first in the concatenation
    localparam work_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

[rtl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, one byte per beat, digest out as eight words.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle while the block is filling. The 64th
// byte of a block starts compression: the 64 rounds run on the shared round
// unit, one round per cycle, and the result is then folded into the hash;
// byte_stall is high throughout. An end-of-message beat starts padding,
// which shifts one pad or length byte into the block buffer per cycle until
// the block is full, with a second padded block when the length spills out
// of the first, and a compression after each padded block. The eight
// digest words then leave through an output register, one per cycle when
// digest_stall is low; the next message may begin while the last word waits.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  sha256_pkg::in_beat_t   byte_beat,
    output logic                   digest_valid,
    input  logic                   digest_stall,
    output sha256_pkg::out_beat_t  digest_beat
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t      state_reg,      state_next;
    work_t       hash_reg,       hash_next;
    work_t       work_reg,       work_next;
    logic [511:0] sched_reg,     sched_next;
    logic [5:0]  fill_reg,       fill_next;
    logic [63:0] bits_reg,       bits_next;
    logic [5:0]  round_reg,      round_next;
    logic        pad_active_reg, pad_active_next;
    logic        mark_done_reg,  mark_done_next;
    logic        len_here_reg,   len_here_next;
    logic        comp_last_reg,  comp_last_next;
    logic [2:0]  idx_reg,        idx_next;
    logic        out_valid_reg,  out_valid_next;
    out_beat_t   out_reg,        out_next;

    work_t       round_work;
    word_t       round_sched;
    logic [7:0]  pad_byte;

    sha256_round u_round (
        .work       (work_reg),
        .sched      (sched_reg),
        .round_idx  (round_reg),
        .work_next  (round_work),
        .sched_word (round_sched)
    );

    assign byte_stall   = (state_reg != ST_IDLE);
    assign digest_valid = out_valid_reg;
    assign digest_beat  = out_reg;

    // Pick the next pad byte: marker, zeros, then the length MSB first
    always_comb
    begin
        if (!mark_done_reg)
            pad_byte = PAD_MARK;
        else if (len_here_reg && (fill_reg >= 6'd56))
            pad_byte = bits_reg[63:56];
        else
            pad_byte = 8'h00;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        hash_next       = hash_reg;
        work_next       = work_reg;
        sched_next      = sched_reg;
        fill_next       = fill_reg;
        bits_next       = bits_reg;
        round_next      = round_reg;
        pad_active_next = pad_active_reg;
        mark_done_next  = mark_done_reg;
        len_here_next   = len_here_reg;
        comp_last_next  = comp_last_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        // Drop the output beat once taken
        if (out_valid_reg && !digest_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    if (byte_beat.end_of_message)
                    begin
                        pad_active_next = 1'b1;
                        mark_done_next  = 1'b0;
                        len_here_next   = 1'b0;
                    end
                    if (byte_beat.byte_present)
                    begin
                        sched_next = {sched_reg[503:0], byte_beat.data_byte};
                        bits_next  = bits_reg + 64'd8;
                        fill_next  = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            state_next     = ST_COMP;
                            work_next      = hash_reg;
                            round_next     = 6'd0;
                            comp_last_next = 1'b0;
                        end
                        else if (byte_beat.end_of_message)
                            state_next = ST_PAD;
                    end
                    else if (byte_beat.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                sched_next = {sched_reg[503:0], pad_byte};
                fill_next  = fill_reg + 6'd1;
                if (!mark_done_reg)
                begin
                    mark_done_next = 1'b1;
                    if (fill_reg < 6'd56)
                        len_here_next = 1'b1;
                end
                else if (len_here_reg && (fill_reg >= 6'd56))
                    bits_next = {bits_reg[55:0], 8'h00};
                if (fill_reg == 6'd63)
                begin
                    state_next     = ST_COMP;
                    work_next      = hash_reg;
                    round_next     = 6'd0;
                    comp_last_next = len_here_reg;
                end
            end
            ST_COMP:
            begin
                work_next  = round_work;
                sched_next = {sched_reg[479:0], round_sched};
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    hash_next[i] = hash_reg[i] + work_reg[i];
                if (!pad_active_reg)
                    state_next = ST_IDLE;
                else if (comp_last_reg)
                begin
                    state_next = ST_EMIT;
                    idx_next   = 3'd0;
                end
                else
                begin
                    state_next    = ST_PAD;
                    len_here_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.digest_word = hash_reg[idx_reg];
                    out_next.word_number = idx_reg;
                    out_next.final_word  = (idx_reg == 3'd7);
                    idx_next             = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next      = ST_IDLE;
                        hash_next       = INIT_HASH;
                        fill_next       = 6'd0;
                        bits_next       = 64'd0;
                        pad_active_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hash_reg       <= INIT_HASH;
            fill_reg       <= 6'd0;
            bits_reg       <= 64'd0;
            round_reg      <= 6'd0;
            pad_active_reg <= 1'b0;
            mark_done_reg  <= 1'b0;
            len_here_reg   <= 1'b0;
            comp_last_reg  <= 1'b0;
            idx_reg        <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hash_reg       <= hash_next;
            fill_reg       <= fill_next;
            bits_reg       <= bits_next;
            round_reg      <= round_next;
            pad_active_reg <= pad_active_next;
            mark_done_reg  <= mark_done_next;
            len_here_reg   <= len_here_next;
            comp_last_reg  <= comp_last_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
        out_reg   <= out_next;
    end

endmodule

[rtl/sha256_round.sv]
// ----------------------------------------------------------------------------
// sha256_round
// One SHA-256 compression round plus the matching message schedule word,
// shared by all 64 rounds of every block.
// ----------------------------------------------------------------------------
module sha256_round (
    input  sha256_pkg::work_t  work,
    input  sha256_pkg::sched_t sched,
    input  logic [5:0]         round_idx,
    output sha256_pkg::work_t  work_next,
    output sha256_pkg::word_t  sched_word
);
    import sha256_pkg::*;

    word_t w0;
    word_t w1;
    word_t w9;
    word_t w14;
    word_t s0;
    word_t s1;
    word_t e1;
    word_t ch;
    word_t a0;
    word_t mj;
    word_t t1;
    word_t t2;

    // Tap the schedule window, oldest word first
    assign w0  = sched[15];
    assign w1  = sched[14];
    assign w9  = sched[6];
    assign w14 = sched[1];

    // Expand the schedule word that enters the window
    assign s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    assign s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]}
              ^ {10'b0, w14[31:10]};
    assign sched_word = w0 + s0 + w9 + s1;

    // Round function
    assign e1 = {work[4][5:0], work[4][31:6]} ^ {work[4][10:0], work[4][31:11]}
              ^ {work[4][24:0], work[4][31:25]};
    assign ch = (work[4] & work[5]) ^ (~work[4] & work[6]);
    assign t1 = work[7] + e1 + ch + round_k(round_idx) + w0;
    assign a0 = {work[0][1:0], work[0][31:2]} ^ {work[0][12:0], work[0][31:13]}
              ^ {work[0][21:0], work[0][31:22]};
    assign mj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    assign t2 = a0 + mj;

    // Rotate the round variables
    always_comb
    begin
        work_next[0] = t1 + t2;
        work_next[1] = work[0];
        work_next[2] = work[1];
        work_next[3] = work[2];
        work_next[4] = work[3] + t1;
        work_next[5] = work[4];
        work_next[6] = work[5];
        work_next[7] = work[6];
    end

endmodule
